// File: rtl/core/htfv_pkg.sv
package htfv_pkg;

  // Field widths of the transaction and of the configuration registers.
  localparam int unsigned RadW     = 16;
  localparam int unsigned LenW     = 16;
  localparam int unsigned LevelW   = 17;
  localparam int unsigned AreaW    = 34;
  localparam int unsigned VolW     = 50;
  localparam int unsigned FlagW    = 2;
  localparam int unsigned CfgIdxW  = 1;

  // Binary angle: a full turn is 2^32, results stay within a quarter turn.
  localparam int unsigned AngleW   = 31;
  localparam int unsigned ZW       = 34;
  localparam logic [AngleW-1:0] QuarterTurn = 31'h4000_0000;

  // Pi with 62 fraction bits.
  localparam logic [63:0] PiQ62 = 64'hC90F_DAA2_2168_C235;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RADIUS = 1'b0,
    CFG_LENGTH = 1'b1
  } cfg_idx_e;

  typedef enum logic [FlagW-1:0] {
    RANGE_OK   = 2'd0,
    RANGE_OVER = 2'd1,
    RANGE_ZERO = 2'd2
  } range_e;

  // Classification of one level sample, carried along the back pipeline.
  typedef struct packed {
    logic zero_r;
    logic over;
    logic upper;
  } tag_t;

  // Entry of the queue between the front and the back.
  typedef struct packed {
    tag_t            tag;
    logic [RadW-1:0] offset;
  } item_t;

  // Arctangent of 2^-i in binary angle units.
  function automatic logic [31:0] atan_bin(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:  val = 32'h2000_0000;
      5'd1:  val = 32'h12E4_051E;
      5'd2:  val = 32'h09FB_385B;
      5'd3:  val = 32'h0511_11D4;
      5'd4:  val = 32'h028B_0D43;
      5'd5:  val = 32'h0145_D7E1;
      5'd6:  val = 32'h00A2_F61E;
      5'd7:  val = 32'h0051_7C55;
      5'd8:  val = 32'h0028_BE53;
      5'd9:  val = 32'h0014_5F2F;
      5'd10: val = 32'h000A_2F98;
      5'd11: val = 32'h0005_17CC;
      5'd12: val = 32'h0002_8BE6;
      5'd13: val = 32'h0001_45F3;
      5'd14: val = 32'h0000_A2FA;
      5'd15: val = 32'h0000_517D;
      5'd16: val = 32'h0000_28BE;
      5'd17: val = 32'h0000_145F;
      5'd18: val = 32'h0000_0A30;
      5'd19: val = 32'h0000_0518;
      5'd20: val = 32'h0000_028C;
      5'd21: val = 32'h0000_0146;
      5'd22: val = 32'h0000_00A3;
      5'd23: val = 32'h0000_0051;
      5'd24: val = 32'h0000_0029;
      5'd25: val = 32'h0000_0014;
      5'd26: val = 32'h0000_000A;
      5'd27: val = 32'h0000_0005;
      5'd28: val = 32'h0000_0003;
      5'd29: val = 32'h0000_0001;
      5'd30: val = 32'h0000_0001;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/core/htfv_front.sv
module htfv_front import htfv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [LevelW-1:0] fill_level_i,
  input  logic [RadW-1:0]   radius_i,
  input  logic              q_full_i,
  output logic              busy_o,
  output logic              push_o,
  output item_t             item_o
);

  logic        valid_q, valid_d;
  item_t       item_q, item_d;
  logic        ready;
  logic        accept;
  logic [LevelW-1:0] rad_ext;
  logic [LevelW-1:0] diam;
  logic [LevelW-1:0] dist_wide;

  // The stage takes a new transaction once its entry has moved on to the queue.
  assign ready  = !valid_q || !q_full_i;
  assign accept = start_i && ready;
  assign busy_o = !ready;
  assign push_o = valid_q && !q_full_i;
  assign item_o = item_q;

  // Classify the level against the radius and fold it onto the lower half.
  always_comb begin
    rad_ext = {1'b0, radius_i};
    diam    = {radius_i, 1'b0};
    item_d.tag.zero_r = (radius_i == '0);
    item_d.tag.over   = (fill_level_i > diam);
    item_d.tag.upper  = (fill_level_i > rad_ext);
    dist_wide = item_d.tag.upper ? (fill_level_i - rad_ext) : (rad_ext - fill_level_i);
    if (item_d.tag.zero_r || item_d.tag.over) begin
      item_d.offset = '0;
    end else begin
      item_d.offset = dist_wide[RadW-1:0];
    end
  end

  assign valid_d = accept || (valid_q && q_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// File: rtl/core/htfv_fifo.sv
module htfv_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             pop;

  // The consumer drains one entry in every cycle that one is present.
  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign pop     = valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(push_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // The fill level never passes the depth, and nobody writes into a full queue.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

endmodule

// File: rtl/core/htfv_div.sv
module htfv_div import htfv_pkg::*; #(
  parameter int unsigned AngleFracBits = 24,
  parameter int unsigned SideW         = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [RadW-1:0]        dist_i,
  input  logic [RadW-1:0]        radius_i,
  input  logic [SideW-1:0]       side_i,
  output logic                   valid_o,
  output logic [AngleFracBits:0] quot_o,
  output logic [SideW-1:0]       side_o
);

  // Rounded quotient dist * 2^F / radius, one quotient bit per stage.
  localparam int unsigned F  = AngleFracBits;
  localparam int unsigned N  = F + 1;
  localparam int unsigned NW = RadW + F + 1;

  logic [NW-1:0]    num;
  logic [RadW-1:0]  rem_q  [N];
  logic [F:0]       low_q  [N];
  logic [F:0]       quo_q  [N];
  logic [SideW-1:0] side_q [N];
  logic             vld_q  [N];

  // Adding half the radius turns the truncating division into rounding.
  // The upper part of the numerator is already below the radius.
  assign num = {1'b0, dist_i, {F{1'b0}}} + NW'(radius_i >> 1);

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RadW-1:0]  rem_in;
    logic [F:0]       low_in;
    logic [F:0]       quo_in;
    logic [SideW-1:0] side_in;
    logic             vld_in;
    logic [RadW:0]    trial;
    logic             fit;

    if (k == 0) begin : g_first
      assign rem_in  = num[NW-1:F+1];
      assign low_in  = num[F:0];
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Restoring step: bring down the next numerator bit and try the radius.
    assign trial = {rem_in, low_in[F]};
    assign fit   = (trial >= {1'b0, radius_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= fit ? RadW'(trial - {1'b0, radius_i}) : trial[RadW-1:0];
      low_q[k]  <= {low_in[F-1:0], 1'b0};
      quo_q[k]  <= {quo_in[F-1:0], fit};
      side_q[k] <= side_in;
    end
  end

  assign valid_o = vld_q[N-1];
  assign quot_o  = quo_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// File: rtl/core/htfv_sqrt.sv
module htfv_sqrt import htfv_pkg::*; #(
  parameter int unsigned AngleFracBits = 24,
  parameter int unsigned SideW         = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [2*AngleFracBits:0] rad_i,
  input  logic [SideW-1:0]         side_i,
  output logic                     valid_o,
  output logic [AngleFracBits:0]   root_o,
  output logic [SideW-1:0]         side_o
);

  // Floor square root, digit by digit: one root bit per stage.
  localparam int unsigned F  = AngleFracBits;
  localparam int unsigned N  = F + 1;
  localparam int unsigned RW = F + 3;
  localparam int unsigned DW = 2 * F + 2;

  logic [RW-1:0]    rem_q  [N];
  logic [DW-1:0]    rad_q  [N];
  logic [F:0]       root_q [N];
  logic [SideW-1:0] side_q [N];
  logic             vld_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW-1:0]    rem_in;
    logic [DW-1:0]    rad_in;
    logic [F:0]       root_in;
    logic [SideW-1:0] side_in;
    logic             vld_in;
    logic [RW+1:0]    trial;
    logic [RW+1:0]    cand;
    logic             fit;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = {1'b0, rad_i};
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Bring down the next pair of radicand bits and test 4*root + 1.
    assign trial = {rem_in, rad_in[DW-1:DW-2]};
    assign cand  = (RW + 2)'({root_in, 2'b01});
    assign fit   = (trial >= cand);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= fit ? RW'(trial - cand) : RW'(trial);
      rad_q[k]  <= {rad_in[DW-3:0], 2'b00};
      root_q[k] <= {root_in[F-1:0], fit};
      side_q[k] <= side_in;
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// File: rtl/core/htfv_cordic.sv
module htfv_cordic import htfv_pkg::*; #(
  parameter int unsigned AngleFracBits = 24,
  parameter int unsigned SideW         = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [AngleFracBits:0] x_i,
  input  logic [AngleFracBits:0] s_i,
  input  logic [SideW-1:0]       side_i,
  output logic                   valid_o,
  output logic [AngleW-1:0]      angle_o,
  output logic [SideW-1:0]       side_o
);

  // Vectoring CORDIC: one micro-rotation per stage, then a clamp stage.
  localparam int unsigned F  = AngleFracBits;
  localparam int unsigned NI = (F < 32) ? F : 32;
  localparam int unsigned XW = F + 4;
  localparam logic signed [ZW-1:0] ZMax = ZW'(QuarterTurn);

  logic signed [XW-1:0] x_q    [NI];
  logic signed [XW-1:0] y_q    [NI];
  logic signed [ZW-1:0] z_q    [NI];
  logic                 xz_q   [NI];
  logic                 sz_q   [NI];
  logic [SideW-1:0]     side_q [NI];
  logic                 vld_q  [NI];

  logic                 out_vld_q;
  logic [AngleW-1:0]    angle_q, angle_d;
  logic [SideW-1:0]     out_side_q;
  logic signed [ZW-1:0] z_last;

  // Arithmetic shift that rounds toward zero, as on a magnitude.
  function automatic logic signed [XW-1:0] shr_tz(input logic signed [XW-1:0] v,
                                                  input int unsigned sh);
    logic signed [XW-1:0] mag;
    mag = v[XW-1] ? -v : v;
    mag = mag >>> sh;
    return v[XW-1] ? -mag : mag;
  endfunction

  for (genvar k = 0; k < NI; k++) begin : g_stage
    logic signed [XW-1:0] x_in;
    logic signed [XW-1:0] y_in;
    logic signed [ZW-1:0] z_in;
    logic                 xz_in;
    logic                 sz_in;
    logic [SideW-1:0]     side_in;
    logic                 vld_in;
    logic                 dir;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] step;

    if (k == 0) begin : g_first
      assign x_in    = signed'({3'b000, x_i});
      assign y_in    = signed'({3'b000, s_i});
      assign z_in    = '0;
      assign xz_in   = (x_i == '0);
      assign sz_in   = (s_i == '0);
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign x_in    = x_q[k-1];
      assign y_in    = y_q[k-1];
      assign z_in    = z_q[k-1];
      assign xz_in   = xz_q[k-1];
      assign sz_in   = sz_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Rotate toward the x axis and accumulate the angle turned.
    assign dir  = !y_in[XW-1] && (y_in != '0);
    assign xs   = shr_tz(x_in, k);
    assign ys   = shr_tz(y_in, k);
    assign step = signed'({2'b00, atan_bin(5'(k))});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[k]    <= dir ? (x_in + ys) : (x_in - ys);
      y_q[k]    <= dir ? (y_in - xs) : (y_in + xs);
      z_q[k]    <= dir ? (z_in + step) : (z_in - step);
      xz_q[k]   <= xz_in;
      sz_q[k]   <= sz_in;
      side_q[k] <= side_in;
    end
  end

  // Exact answers on the axes, otherwise the angle clamped to a quarter turn.
  assign z_last = z_q[NI-1];

  always_comb begin
    if (xz_q[NI-1]) begin
      angle_d = QuarterTurn;
    end else if (sz_q[NI-1] || z_last[ZW-1]) begin
      angle_d = '0;
    end else if (z_last > ZMax) begin
      angle_d = QuarterTurn;
    end else begin
      angle_d = z_last[AngleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[NI-1];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q    <= angle_d;
    out_side_q <= side_q[NI-1];
  end

  assign valid_o = out_vld_q;
  assign angle_o = angle_q;
  assign side_o  = out_side_q;

endmodule

// File: rtl/core/htfv_back.sv
module htfv_back import htfv_pkg::*; #(
  parameter int unsigned AngleFracBits = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  item_t             item_i,
  input  logic [RadW-1:0]   radius_i,
  input  logic [LenW-1:0]   length_i,
  output logic              done_o,
  output logic [AreaW-1:0]  wetted_area_o,
  output logic [VolW-1:0]   fill_volume_o,
  output logic [FlagW-1:0]  range_flag_o
);

  localparam int unsigned F        = AngleFracBits;
  localparam int unsigned XW       = F + 1;
  localparam int unsigned NW       = 2 * F + 1;
  localparam int unsigned GW       = F + 2;
  localparam int unsigned TagW     = $bits(tag_t);
  localparam int unsigned SqSideW  = TagW + XW;
  localparam int unsigned CoSideW  = TagW + GW;
  localparam int unsigned RsqW     = 2 * RadW;
  localparam int unsigned RlW      = 2 * RadW + LenW;
  localparam int unsigned VH       = RlW / 2;
  localparam int unsigned PW       = 95;
  localparam int unsigned ThetaSh  = 93 - F;
  localparam int unsigned AraW     = RsqW + GW;
  localparam int unsigned VpW      = VH + GW;
  localparam int unsigned VsW      = 2 * VH + GW + 1;
  localparam logic [XW-1:0] One    = XW'(1) << F;
  localparam logic [64:0] PiBias   = {1'b0, PiQ62} + (65'(1) << (61 - F));
  localparam logic [GW-1:0] PiF    = GW'(PiBias >> (62 - F));

  // Radius squared and its product with the length follow the registers.
  logic [RsqW-1:0] rsq_q;
  logic [RlW-1:0]  rl_q;

  always_ff @(posedge clk_i) begin
    rsq_q <= RsqW'(radius_i) * RsqW'(radius_i);
    rl_q  <= RlW'(rsq_q) * RlW'(length_i);
  end

  // Normalized distance from the center.
  logic            div_valid;
  logic [XW-1:0]   div_quot;
  logic [TagW-1:0] div_side;

  htfv_div #(
    .AngleFracBits(F),
    .SideW        (TagW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_valid_i),
    .dist_i  (item_i.offset),
    .radius_i(radius_i),
    .side_i  (item_i.tag),
    .valid_o (div_valid),
    .quot_o  (div_quot),
    .side_o  (div_side)
  );

  // Clamp to one and form 1 - x^2 as (1 - x) * (1 + x).
  logic [XW-1:0]   xc;
  logic [XW-1:0]   lo_dif;
  logic [XW:0]     hi_sum;
  logic [2*XW:0]   sq_prod;
  logic            cl_valid_q;
  logic [XW-1:0]   cl_x_q;
  logic [NW-1:0]   cl_n_q;
  logic [TagW-1:0] cl_tag_q;

  assign xc      = (div_quot > One) ? One : div_quot;
  assign lo_dif  = One - xc;
  assign hi_sum  = {1'b0, One} + {1'b0, xc};
  assign sq_prod = (2 * XW + 1)'(lo_dif) * (2 * XW + 1)'(hi_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_valid_q <= 1'b0;
    end else begin
      cl_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cl_x_q   <= xc;
    cl_n_q   <= sq_prod[NW-1:0];
    cl_tag_q <= div_side;
  end

  // Sine part of the angle.
  logic               sq_valid;
  logic [XW-1:0]      sq_root;
  logic [SqSideW-1:0] sq_side;

  htfv_sqrt #(
    .AngleFracBits(F),
    .SideW        (SqSideW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(cl_valid_q),
    .rad_i  (cl_n_q),
    .side_i ({cl_tag_q, cl_x_q}),
    .valid_o(sq_valid),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // Product x * sqrt(1 - x^2), rounded on the way into the CORDIC.
  logic [2*XW-1:0] xs_prod;
  logic            p_valid_q;
  logic [XW-1:0]   p_x_q;
  logic [XW-1:0]   p_s_q;
  logic [2*XW-1:0] p_prod_q;
  logic [TagW-1:0] p_tag_q;
  logic [2*XW-1:0] prod_rnd;
  logic [GW-1:0]   prod_r;

  assign xs_prod = (2 * XW)'(sq_side[XW-1:0]) * (2 * XW)'(sq_root);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    p_x_q    <= sq_side[XW-1:0];
    p_s_q    <= sq_root;
    p_prod_q <= xs_prod;
    p_tag_q  <= sq_side[SqSideW-1:XW];
  end

  assign prod_rnd = p_prod_q + ((2 * XW)'(1) << (F - 1));
  assign prod_r   = GW'(prod_rnd >> F);

  // Arccosine in binary angle units.
  logic               co_valid;
  logic [AngleW-1:0]  co_angle;
  logic [CoSideW-1:0] co_side;

  htfv_cordic #(
    .AngleFracBits(F),
    .SideW        (CoSideW)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(p_valid_q),
    .x_i    (p_x_q),
    .s_i    (p_s_q),
    .side_i ({p_tag_q, prod_r}),
    .valid_o(co_valid),
    .angle_o(co_angle),
    .side_o (co_side)
  );

  // Binary angle to radians: two half-width partial products of pi.
  logic [AngleW+31:0]  pl_d, ph_d;
  logic                t1_valid_q;
  logic [AngleW+31:0]  pl_q, ph_q;
  logic [CoSideW-1:0]  t1_side_q;

  assign pl_d = (AngleW + 32)'(co_angle) * (AngleW + 32)'(PiQ62[31:0]);
  assign ph_d = (AngleW + 32)'(co_angle) * (AngleW + 32)'(PiQ62[63:32]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
    end else begin
      t1_valid_q <= co_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q      <= pl_d;
    ph_q      <= ph_d;
    t1_side_q <= co_side;
  end

  // Sum the partial products and round away the low bits.
  logic [PW-1:0]      pi_sum;
  logic               t2_valid_q;
  logic [GW-1:0]      theta_q;
  logic [CoSideW-1:0] t2_side_q;

  assign pi_sum = {ph_q, 32'h0000_0000} + PW'(pl_q) + (PW'(1) << (ThetaSh - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t2_valid_q <= 1'b0;
    end else begin
      t2_valid_q <= t1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    theta_q   <= GW'(pi_sum >> ThetaSh);
    t2_side_q <= t1_side_q;
  end

  // Segment angle term of the lower half, floored at zero.
  logic [GW-1:0]   t2_prod;
  logic            g1_valid_q;
  logic [GW-1:0]   g0_q;
  logic [TagW-1:0] g1_tag_q;

  assign t2_prod = t2_side_q[GW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_valid_q <= 1'b0;
    end else begin
      g1_valid_q <= t2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g0_q     <= (theta_q > t2_prod) ? (theta_q - t2_prod) : '0;
    g1_tag_q <= t2_side_q[CoSideW-1:GW];
  end

  // Zero for a zero radius, mirror for the upper half, saturate above the diameter.
  tag_t          g1_tag;
  logic [GW-1:0] g_d;
  logic          g2_valid_q;
  logic [GW-1:0] g_q;
  tag_t          g2_tag_q;

  assign g1_tag = g1_tag_q;

  always_comb begin
    if (g1_tag.zero_r) begin
      g_d = '0;
    end else if (g1_tag.over) begin
      g_d = PiF;
    end else if (g1_tag.upper) begin
      g_d = (PiF > g0_q) ? (PiF - g0_q) : '0;
    end else begin
      g_d = g0_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g2_valid_q <= 1'b0;
    end else begin
      g2_valid_q <= g1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q      <= g_d;
    g2_tag_q <= g1_tag;
  end

  // Scale by the radius squared, and by the split radius-squared-length.
  logic [AraW-1:0] area_raw_d;
  logic [VpW-1:0]  vlo_d, vhi_d;
  logic            m1_valid_q;
  logic [AraW-1:0] area_raw_q;
  logic [VpW-1:0]  vlo_q, vhi_q;
  tag_t            m1_tag_q;

  assign area_raw_d = AraW'(rsq_q) * AraW'(g_q);
  assign vlo_d      = VpW'(rl_q[VH-1:0]) * VpW'(g_q);
  assign vhi_d      = VpW'(rl_q[RlW-1:VH]) * VpW'(g_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
    end else begin
      m1_valid_q <= g2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    area_raw_q <= area_raw_d;
    vlo_q      <= vlo_d;
    vhi_q      <= vhi_d;
    m1_tag_q   <= g2_tag_q;
  end

  // Round both results and register them for the output strobe.
  logic [AraW-1:0]  area_sum;
  logic [VsW-1:0]   vol_sum;
  logic [FlagW-1:0] flag_d;
  logic             done_q;
  logic [AreaW-1:0] area_q;
  logic [VolW-1:0]  vol_q;
  logic [FlagW-1:0] flag_q;

  assign area_sum = area_raw_q + (AraW'(1) << (F - 1));
  assign vol_sum  = {1'b0, vhi_q, {VH{1'b0}}} + VsW'(vlo_q) + (VsW'(1) << (F - 1));

  always_comb begin
    if (m1_tag_q.zero_r) begin
      flag_d = RANGE_ZERO;
    end else if (m1_tag_q.over) begin
      flag_d = RANGE_OVER;
    end else begin
      flag_d = RANGE_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= m1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    area_q <= AreaW'(area_sum >> F);
    vol_q  <= VolW'(vol_sum >> F);
    flag_q <= flag_d;
  end

  assign done_o        = done_q;
  assign wetted_area_o = area_q;
  assign fill_volume_o = vol_q;
  assign range_flag_o  = flag_q;

endmodule

// File: rtl/core/horizontal_tank_fill_volume.sv
// Level-to-volume converter for a horizontal cylindrical tank. Hold start_i
// high with a level in fill_level_i; the level is taken at the rising edge at
// which busy_o is low, and busy_o stays low in normal use, so a level can be
// given in every cycle. Each level yields exactly one result, shown for a
// single cycle with done_o high, in the order the levels came in; the receiver
// cannot stall, so results cannot be held off.
// The pipelined divider and square root resolve one bit per stage, and the
// CORDIC takes one rotation per stage. Write the radius and length through
// cfg_we_i while no transaction is in flight.
module horizontal_tank_fill_volume import htfv_pkg::*; #(
  parameter int unsigned AngleFracBits = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [LevelW-1:0]  fill_level_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RadW-1:0]    cfg_wdata_i,
  output logic               done_o,
  output logic [AreaW-1:0]   wetted_area_o,
  output logic [VolW-1:0]    fill_volume_o,
  output logic [FlagW-1:0]   range_flag_o
);

  localparam int unsigned QueueDepth = 2;

  logic [RadW-1:0] radius_q;
  logic [LenW-1:0] length_q;
  cfg_idx_e        cfg_idx;

  // Configuration registers.
  assign cfg_idx = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
      length_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        CFG_RADIUS: radius_q <= cfg_wdata_i;
        CFG_LENGTH: length_q <= LenW'(cfg_wdata_i);
      endcase
    end
  end

  // Front: accept and classify the level.
  logic  q_full;
  logic  q_push;
  item_t front_item;

  htfv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .fill_level_i(fill_level_i),
    .radius_i    (radius_q),
    .q_full_i    (q_full),
    .busy_o      (busy_o),
    .push_o      (q_push),
    .item_o      (front_item)
  );

  // Queue between the front and the back.
  logic                     q_valid;
  logic [$bits(item_t)-1:0] q_data;
  item_t                    back_item;

  htfv_fifo #(
    .Width($bits(item_t)),
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (front_item),
    .full_o (q_full),
    .valid_o(q_valid),
    .data_o (q_data)
  );

  assign back_item = item_t'(q_data);

  // Back: segment area and volume.
  htfv_back #(
    .AngleFracBits(AngleFracBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (back_item),
    .radius_i     (radius_q),
    .length_i     (length_q),
    .done_o       (done_o),
    .wetted_area_o(wetted_area_o),
    .fill_volume_o(fill_volume_o),
    .range_flag_o (range_flag_o)
  );

  // The back drains the queue every cycle, so the front never stalls.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("front stalled behind the queue");

  // A zero radius gives empty results.
  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (range_flag_o == RANGE_ZERO)) |-> ((wetted_area_o == '0) && (fill_volume_o == '0)))
    else $error("zero radius with nonzero result");

  // A saturated level reports the full circle, which is never empty.
  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (range_flag_o == RANGE_OVER)) |-> (wetted_area_o != '0))
    else $error("saturated level with empty area");

endmodule
